>>> hdl/sfs_pkg.sv
// ============================================================================
// sfs_pkg
// Types and constants shared by the sprite frame sequencer files.
// ============================================================================
`default_nettype none

package sfs_pkg;

   localparam int unsigned MAX_FRAMES = 64;
   localparam int unsigned MAX_CLIPS  = 16;
   localparam int unsigned FRAME_AW   = 6;
   localparam int unsigned CLIP_AW    = 4;

   localparam logic [11:0] SPEED_RESET = 12'd256;
   localparam logic [23:0] TIMER_MAX   = 24'hFFFFFF;

   typedef enum logic [2:0] {
      REQ_CLEAR  = 3'd0,
      REQ_FRAME  = 3'd1,
      REQ_STRIP  = 3'd2,
      REQ_CLIP   = 3'd3,
      REQ_PLAY   = 3'd4,
      REQ_STOP   = 3'd5,
      REQ_TICK   = 3'd6,
      REQ_RESET  = 3'd7
   } req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_STRIP,
      ST_T_MUL,
      ST_T_ADD,
      ST_ADV_IDX,
      ST_ADV_CHK,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_DIV,
      ST_R_CLIP,
      ST_R_CHK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        w;
      logic [15:0]        h;
      logic [15:0]        dur;
   } frame_entry_type;

   typedef struct packed {
      logic [5:0] first;
      logic [6:0] count;
      logic       loop;
   } clip_entry_type;

   typedef struct packed {
      logic        start;
      logic [23:0] dividend;
      logic [21:0] divisor;
   } mod_cmd_type;

   typedef struct packed {
      logic        done;
      logic [21:0] rem;
   } mod_rsp_type;

endpackage

`default_nettype wire

>>> hdl/sfs_if.sv
// ============================================================================
// sfs_req_if / sfs_rsp_if
// Request and result channels with valid/ready handshake.
// ============================================================================
`default_nettype none

interface sfs_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         req_type;
   logic signed [15:0] rect_x;
   logic signed [15:0] rect_y;
   logic [15:0]        rect_w;
   logic [15:0]        rect_h;
   logic [15:0]        duration;
   logic [5:0]         start_frame;
   logic [6:0]         frame_num;
   logic               loop_mode;
   logic [3:0]         clip_sel;
   logic               restart;
   logic [15:0]        dt;

   modport source (output valid, req_type, rect_x, rect_y, rect_w, rect_h, duration,
                   start_frame, frame_num, loop_mode, clip_sel, restart, dt,
                   input ready);
   modport sink (input valid, req_type, rect_x, rect_y, rect_w, rect_h, duration,
                 start_frame, frame_num, loop_mode, clip_sel, restart, dt,
                 output ready);
endinterface

interface sfs_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic [5:0]         assigned_index;
   logic [5:0]         frame_shown;
   logic signed [15:0] region_x;
   logic signed [15:0] region_y;
   logic [15:0]        region_w;
   logic [15:0]        region_h;
   logic               region_valid;
   logic               playing;
   logic               finished;

   modport source (output valid, status, assigned_index, frame_shown, region_x, region_y,
                   region_w, region_h, region_valid, playing, finished,
                   input ready);
   modport sink (input valid, status, assigned_index, frame_shown, region_x, region_y,
                 region_w, region_h, region_valid, playing, finished,
                 output ready);
endinterface

`default_nettype wire

>>> hdl/sfs_frame_store.sv
// ============================================================================
// sfs_frame_store
// Frame table: rectangle and duration per entry, one write and one
// registered read port.
// ============================================================================
`default_nettype none

module sfs_frame_store
   import sfs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [FRAME_AW-1:0] wr_addr,
   input  wire frame_entry_type     wr_data,
   input  wire logic [FRAME_AW-1:0] rd_addr,
   output frame_entry_type          rd_data
);

   frame_entry_type mem [MAX_FRAMES];
   frame_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/sfs_clip_store.sv
// ============================================================================
// sfs_clip_store
// Clip table: first frame, frame count and loop flag per clip.
// ============================================================================
`default_nettype none

module sfs_clip_store
   import sfs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [CLIP_AW-1:0] wr_addr,
   input  wire clip_entry_type     wr_data,
   input  wire logic [CLIP_AW-1:0] rd_addr,
   output clip_entry_type          rd_data
);

   clip_entry_type mem [MAX_CLIPS];
   clip_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/sfs_mod_unit.sv
// ============================================================================
// sfs_mod_unit
// Restoring remainder unit, one dividend bit per cycle.
// ============================================================================
`default_nettype none

module sfs_mod_unit
   import sfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_cmd_type cmd,
   output mod_rsp_type      rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [23:0] num_ff, num_in;
   logic [21:0] div_ff, div_in;
   logic [22:0] rem_ff, rem_in;
   logic [22:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff[21:0], num_ff[23]};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd23;
         num_in  = cmd.dividend;
         div_in  = cmd.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in the next bit, subtract when it fits
         rem_in = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
         num_in = {num_ff[22:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff[21:0];

endmodule

`default_nettype wire

>>> hdl/sprite_frame_sequencer.sv
// ============================================================================
// sprite_frame_sequencer
// Sprite animation frame sequencer: frame and clip tables in memory, a
// player that advances through a clip on each tick.
// ============================================================================
// Each request is latched on accept and executed; the clip entry and the shown frame
// are then read and the result is registered. A strip writes its frames in turn,
// stopping on a full table; a tick scales dt, advances frame by frame and, on a loop
// wrap, sums the clip durations and runs the remainder unit (at most once per tick).
// One request is processed at a time; ready returns once its result is registered.
// Reset clears counts, player state and speed (256); tables are left as is.
`default_nettype none

module sprite_frame_sequencer
   import sfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   sfs_req_if.sink          req_bus,
   sfs_rsp_if.source        rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [11:0] csr_wdata
);

   state_type state_ff, state_in;

   // latched request beat
   req_code_type       rq_type_ff;
   logic signed [15:0] rq_x_ff, rq_y_ff;
   logic [15:0]        rq_w_ff, rq_h_ff, rq_dur_ff, rq_dt_ff;
   logic [5:0]         rq_ff_ff;
   logic [6:0]         rq_fc_ff;
   logic               rq_lm_ff, rq_rs_ff;
   logic [3:0]         rq_ci_ff;

   // player and table counts
   logic [6:0]  frames_used_ff, frames_used_in;
   logic [4:0]  clips_used_ff, clips_used_in;
   logic [3:0]  cur_clip_ff, cur_clip_in;
   logic        selected_ff, selected_in;
   logic [5:0]  fic_ff, fic_in;
   logic [23:0] timer_ff, timer_in;
   logic        playing_ff, playing_in;
   logic        finished_ff, finished_in;
   logic [11:0] speed_ff, speed_in;

   // per-request working registers
   logic        status_ff, status_in;
   logic [5:0]  assigned_ff, assigned_in;
   logic        apply_ff, apply_in;
   logic        folded_ff, folded_in;
   logic [27:0] prod_ff, prod_in;
   logic [5:0]  cl_first_ff, cl_first_in;
   logic [6:0]  cl_count_ff, cl_count_in;
   logic        cl_loop_ff, cl_loop_in;
   logic [6:0]  k_ff, k_in;
   logic [21:0] total_ff, total_in;
   logic signed [23:0] xacc_ff, xacc_in;
   logic [6:0]  strip_i_ff, strip_i_in;
   logic        shown_ok_ff, shown_ok_in;
   logic [5:0]  shown_idx_ff, shown_idx_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               o_status_ff, o_status_in;
   logic [5:0]         o_assigned_ff, o_assigned_in;
   logic [5:0]         o_frame_ff, o_frame_in;
   logic signed [15:0] o_x_ff, o_x_in, o_y_ff, o_y_in;
   logic [15:0]        o_w_ff, o_w_in, o_h_ff, o_h_in;
   logic               o_rv_ff, o_rv_in, o_play_ff, o_play_in, o_fin_ff, o_fin_in;

   // memory ports
   logic                fw_en;
   logic [FRAME_AW-1:0] fw_addr, fr_addr;
   frame_entry_type     fw_data, fr_data;
   logic                cw_en;
   clip_entry_type      cw_data, cr_data;
   mod_cmd_type         mod_cmd;
   mod_rsp_type         mod_rsp;

   logic        req_take;
   logic [6:0]  idx;
   logic [6:0]  nfic;
   logic [24:0] tsum;
   logic [7:0]  clip_end;
   logic [6:0]  sidx;

   sfs_frame_store u_frames (
      .clock   (clock),
      .wr_en   (fw_en),
      .wr_addr (fw_addr),
      .wr_data (fw_data),
      .rd_addr (fr_addr),
      .rd_data (fr_data)
   );

   // clips are only ever read at the current selection
   sfs_clip_store u_clips (
      .clock   (clock),
      .wr_en   (cw_en),
      .wr_addr (clips_used_ff[CLIP_AW-1:0]),
      .wr_data (cw_data),
      .rd_addr (cur_clip_ff),
      .rd_data (cr_data)
   );

   sfs_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (mod_cmd),
      .rsp   (mod_rsp)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in       = state_ff;
      frames_used_in = frames_used_ff;
      clips_used_in  = clips_used_ff;
      cur_clip_in    = cur_clip_ff;
      selected_in    = selected_ff;
      fic_in         = fic_ff;
      timer_in       = timer_ff;
      playing_in     = playing_ff;
      finished_in    = finished_ff;
      speed_in       = speed_ff;
      status_in      = status_ff;
      assigned_in    = assigned_ff;
      apply_in       = apply_ff;
      folded_in      = folded_ff;
      prod_in        = prod_ff;
      cl_first_in    = cl_first_ff;
      cl_count_in    = cl_count_ff;
      cl_loop_in     = cl_loop_ff;
      k_in           = k_ff;
      total_in       = total_ff;
      xacc_in        = xacc_ff;
      strip_i_in     = strip_i_ff;
      shown_ok_in    = shown_ok_ff;
      shown_idx_in   = shown_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      o_status_in    = o_status_ff;
      o_assigned_in  = o_assigned_ff;
      o_frame_in     = o_frame_ff;
      o_x_in         = o_x_ff;
      o_y_in         = o_y_ff;
      o_w_in         = o_w_ff;
      o_h_in         = o_h_ff;
      o_rv_in        = o_rv_ff;
      o_play_in      = o_play_ff;
      o_fin_in       = o_fin_ff;

      fw_en    = 1'b0;
      fw_addr  = frames_used_ff[FRAME_AW-1:0];
      fw_data  = '{x: rq_x_ff, y: rq_y_ff, w: rq_w_ff, h: rq_h_ff, dur: rq_dur_ff};
      fr_addr  = shown_idx_ff;
      cw_en    = 1'b0;
      cw_data  = '{first: rq_ff_ff, count: rq_fc_ff, loop: rq_lm_ff};
      mod_cmd  = '{start: 1'b0, dividend: timer_ff, divisor: total_ff};

      idx      = {1'b0, cl_first_ff} + {1'b0, fic_ff};
      nfic     = {1'b0, fic_ff} + 7'd1;
      tsum     = {1'b0, timer_ff} + {5'd0, prod_ff[27:8]};
      clip_end = {2'd0, rq_ff_ff} + {1'b0, rq_fc_ff};
      sidx     = {1'b0, cl_first_ff} + k_ff;

      if (csr_we) begin
         speed_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               status_in   = 1'b0;
               assigned_in = '0;
               apply_in    = 1'b0;
               state_in    = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_R_CLIP;
            unique case (rq_type_ff)
               REQ_CLEAR: begin
                  // counts only; the player keeps a possibly stale selection
                  frames_used_in = '0;
                  clips_used_in  = '0;
               end
               REQ_FRAME: begin
                  if (frames_used_ff < 7'(MAX_FRAMES) && rq_w_ff != '0 && rq_h_ff != '0
                      && rq_dur_ff != '0) begin
                     fw_en          = 1'b1;
                     assigned_in    = frames_used_ff[5:0];
                     frames_used_in = frames_used_ff + 7'd1;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               REQ_STRIP: begin
                  if (rq_w_ff == '0 || rq_h_ff == '0 || rq_fc_ff == '0 || rq_dur_ff == '0)
                  begin
                     status_in = 1'b1;
                  end else begin
                     assigned_in = frames_used_ff[5:0];
                     xacc_in     = 24'(rq_x_ff);
                     strip_i_in  = '0;
                     state_in    = ST_STRIP;
                  end
               end
               REQ_CLIP: begin
                  if (clips_used_ff < 5'(MAX_CLIPS) && rq_fc_ff != '0
                      && clip_end <= {1'b0, frames_used_ff}) begin
                     cw_en         = 1'b1;
                     assigned_in   = {2'd0, clips_used_ff[3:0]};
                     clips_used_in = clips_used_ff + 5'd1;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               REQ_PLAY: begin
                  if ({1'b0, rq_ci_ff} >= clips_used_ff) begin
                     status_in = 1'b1;
                  end else if (!(!rq_rs_ff && selected_ff && cur_clip_ff == rq_ci_ff)) begin
                     cur_clip_in = rq_ci_ff;
                     selected_in = 1'b1;
                     fic_in      = '0;
                     timer_in    = '0;
                     playing_in  = 1'b1;
                     finished_in = 1'b0;
                     apply_in    = 1'b1;
                  end
               end
               REQ_STOP: begin
                  playing_in = 1'b0;
               end
               REQ_TICK: begin
                  if (playing_ff) begin
                     if (selected_ff && {1'b0, cur_clip_ff} < clips_used_ff) begin
                        state_in = ST_T_MUL;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
               end
               REQ_RESET: begin
                  cur_clip_in = '0;
                  selected_in = 1'b0;
                  fic_in      = '0;
                  timer_in    = '0;
                  playing_in  = 1'b0;
                  finished_in = 1'b0;
                  speed_in    = SPEED_RESET;
               end
               default: begin
               end
            endcase
         end

         ST_STRIP: begin
            // one frame per cycle; stop on a full table
            if (frames_used_ff >= 7'(MAX_FRAMES)) begin
               status_in = 1'b1;
               state_in  = ST_R_CLIP;
            end else begin
               fw_en          = 1'b1;
               fw_data.x      = (xacc_ff > 24'sd32767) ? 16'sh7FFF : xacc_ff[15:0];
               frames_used_in = frames_used_ff + 7'd1;
               xacc_in        = xacc_ff + $signed({8'd0, rq_w_ff});
               strip_i_in     = strip_i_ff + 7'd1;
               if (strip_i_ff + 7'd1 >= rq_fc_ff) begin
                  state_in = ST_R_CLIP;
               end
            end
         end

         ST_T_MUL: begin
            // clip entry is being read at the current selection meanwhile
            prod_in   = {12'd0, rq_dt_ff} * {16'd0, speed_ff};
            folded_in = 1'b0;
            state_in  = ST_T_ADD;
         end

         ST_T_ADD: begin
            timer_in    = tsum[24] ? TIMER_MAX : tsum[23:0];
            cl_first_in = cr_data.first;
            cl_count_in = cr_data.count;
            cl_loop_in  = cr_data.loop;
            if ({1'b0, fic_ff} < cr_data.count
                && ({1'b0, cr_data.first} + {1'b0, fic_ff}) < frames_used_ff) begin
               state_in = ST_ADV_IDX;
            end else begin
               status_in = 1'b1;
               state_in  = ST_R_CLIP;
            end
         end

         ST_ADV_IDX: begin
            if (idx >= frames_used_ff) begin
               apply_in = 1'b1;
               state_in = ST_R_CLIP;
            end else begin
               fr_addr  = idx[FRAME_AW-1:0];
               state_in = ST_ADV_CHK;
            end
         end

         ST_ADV_CHK: begin
            if (fr_data.dur == '0 || timer_ff < {8'd0, fr_data.dur}) begin
               apply_in = 1'b1;
               state_in = ST_R_CLIP;
            end else begin
               timer_in = timer_ff - {8'd0, fr_data.dur};
               if (nfic >= cl_count_ff) begin
                  if (cl_loop_ff) begin
                     fic_in = '0;
                     if (!folded_ff) begin
                        k_in     = '0;
                        total_in = '0;
                        state_in = ST_SUM_RD;
                     end else begin
                        state_in = ST_ADV_IDX;
                     end
                  end else begin
                     // play once: hold the last frame
                     fic_in      = 6'(cl_count_ff - 7'd1);
                     playing_in  = 1'b0;
                     finished_in = 1'b1;
                     apply_in    = 1'b1;
                     state_in    = ST_R_CLIP;
                  end
               end else begin
                  fic_in   = nfic[5:0];
                  state_in = ST_ADV_IDX;
               end
            end
         end

         ST_SUM_RD: begin
            if (k_ff < cl_count_ff && sidx < frames_used_ff) begin
               fr_addr  = sidx[FRAME_AW-1:0];
               state_in = ST_SUM_ACC;
            end else begin
               mod_cmd.start = 1'b1;
               state_in      = ST_DIV;
            end
         end

         ST_SUM_ACC: begin
            total_in = total_ff + {6'd0, fr_data.dur};
            k_in     = k_ff + 7'd1;
            state_in = ST_SUM_RD;
         end

         ST_DIV: begin
            if (mod_rsp.done) begin
               timer_in  = {2'd0, mod_rsp.rem};
               folded_in = 1'b1;
               state_in  = ST_ADV_IDX;
            end
         end

         ST_R_CLIP: begin
            state_in = ST_R_CHK;
         end

         ST_R_CHK: begin
            shown_ok_in  = selected_ff && ({1'b0, cur_clip_ff} < clips_used_ff)
                           && ({1'b0, fic_ff} < cr_data.count)
                           && (({1'b0, cr_data.first} + {1'b0, fic_ff}) < frames_used_ff);
            shown_idx_in = cr_data.first + fic_ff;
            fr_addr      = shown_idx_in;
            state_in     = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               o_status_in   = status_ff || (apply_ff && !shown_ok_ff);
               o_assigned_in = assigned_ff;
               o_frame_in    = shown_ok_ff ? shown_idx_ff : '0;
               o_x_in        = shown_ok_ff ? fr_data.x : '0;
               o_y_in        = shown_ok_ff ? fr_data.y : '0;
               o_w_in        = shown_ok_ff ? fr_data.w : '0;
               o_h_in        = shown_ok_ff ? fr_data.h : '0;
               o_rv_in       = apply_ff && shown_ok_ff && !status_ff;
               o_play_in     = playing_ff;
               o_fin_in      = finished_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frames_used_ff <= '0;
         clips_used_ff  <= '0;
         cur_clip_ff    <= '0;
         selected_ff    <= 1'b0;
         fic_ff         <= '0;
         timer_ff       <= '0;
         playing_ff     <= 1'b0;
         finished_ff    <= 1'b0;
         speed_ff       <= SPEED_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frames_used_ff <= frames_used_in;
         clips_used_ff  <= clips_used_in;
         cur_clip_ff    <= cur_clip_in;
         selected_ff    <= selected_in;
         fic_ff         <= fic_in;
         timer_ff       <= timer_in;
         playing_ff     <= playing_in;
         finished_ff    <= finished_in;
         speed_ff       <= speed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rq_type_ff <= req_code_type'(req_bus.req_type);
         rq_x_ff    <= req_bus.rect_x;
         rq_y_ff    <= req_bus.rect_y;
         rq_w_ff    <= req_bus.rect_w;
         rq_h_ff    <= req_bus.rect_h;
         rq_dur_ff  <= req_bus.duration;
         rq_ff_ff   <= req_bus.start_frame;
         rq_fc_ff   <= req_bus.frame_num;
         rq_lm_ff   <= req_bus.loop_mode;
         rq_ci_ff   <= req_bus.clip_sel;
         rq_rs_ff   <= req_bus.restart;
         rq_dt_ff   <= req_bus.dt;
      end
      status_ff     <= status_in;
      assigned_ff   <= assigned_in;
      apply_ff      <= apply_in;
      folded_ff     <= folded_in;
      prod_ff       <= prod_in;
      cl_first_ff   <= cl_first_in;
      cl_count_ff   <= cl_count_in;
      cl_loop_ff    <= cl_loop_in;
      k_ff          <= k_in;
      total_ff      <= total_in;
      xacc_ff       <= xacc_in;
      strip_i_ff    <= strip_i_in;
      shown_ok_ff   <= shown_ok_in;
      shown_idx_ff  <= shown_idx_in;
      o_status_ff   <= o_status_in;
      o_assigned_ff <= o_assigned_in;
      o_frame_ff    <= o_frame_in;
      o_x_ff        <= o_x_in;
      o_y_ff        <= o_y_in;
      o_w_ff        <= o_w_in;
      o_h_ff        <= o_h_in;
      o_rv_ff       <= o_rv_in;
      o_play_ff     <= o_play_in;
      o_fin_ff      <= o_fin_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = o_status_ff;
   assign rsp_bus.assigned_index = o_assigned_ff;
   assign rsp_bus.frame_shown    = o_frame_ff;
   assign rsp_bus.region_x       = o_x_ff;
   assign rsp_bus.region_y       = o_y_ff;
   assign rsp_bus.region_w       = o_w_ff;
   assign rsp_bus.region_h       = o_h_ff;
   assign rsp_bus.region_valid   = o_rv_ff;
   assign rsp_bus.playing        = o_play_ff;
   assign rsp_bus.finished       = o_fin_ff;

endmodule

`default_nettype wire

>>> bench/tb_sfs_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_sfs_pkg
// Request and result beat records used by the sequencer testbench.
// ============================================================================

package tb_sfs_pkg;
   import sfs_pkg::*;

   typedef struct {
      req_code_type       kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        w;
      logic [15:0]        h;
      logic [15:0]        dur;
      logic [5:0]         first;
      logic [6:0]         count;
      logic               loop;
      logic [3:0]         clip;
      logic               restart;
      logic [15:0]        dt;
   } req_beat_type;

   typedef struct {
      logic               status;
      logic [5:0]         assigned;
      logic [5:0]         frame;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic [15:0]        rw;
      logic [15:0]        rh;
      logic               rvalid;
      logic               playing;
      logic               finished;
   } rsp_beat_type;
endpackage

>>> bench/tb_sprite_frame_sequencer.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_sprite_frame_sequencer
// Drives table builds, play control and ticks into the frame sequencer with
// random gaps and stalls, predicts every result beat and checks each field.
// ============================================================================

module tb_sprite_frame_sequencer;
   import sfs_pkg::*;
   import tb_sfs_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [11:0] csr_wdata = '0;

   sfs_req_if req_bus ();
   sfs_rsp_if rsp_bus ();

   sprite_frame_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state: a private copy of the tables and the player
   // ------------------------------------------------------------------
   frame_entry_type frames_tab [MAX_FRAMES];
   clip_entry_type  clips_tab [MAX_CLIPS];
   int unsigned     n_frames, n_clips;
   logic [3:0]      cur_clip;
   logic            selected;
   int unsigned     pos;
   int unsigned     timer;
   logic            playing_q, finished_q;
   logic [11:0]     speed_q;

   req_beat_type pending_reqs [$];
   rsp_beat_type expected_rsps [$];
   int           mismatches = 0;
   bit           stimulus_done = 0;

   function automatic bit clip_live();
      return selected && cur_clip < n_clips;
   endfunction

   // absolute frame shown, or -1 when nothing valid is shown
   function automatic int shown_index();
      int unsigned idx;
      if (!clip_live()) return -1;
      if (pos >= clips_tab[cur_clip].count) return -1;
      idx = clips_tab[cur_clip].first + pos;
      if (idx >= n_frames) return -1;
      return idx;
   endfunction

   function automatic bit push_frame(logic signed [15:0] x, logic signed [15:0] y,
                                     logic [15:0] w, logic [15:0] h, logic [15:0] d);
      if (n_frames >= MAX_FRAMES || w == 0 || h == 0 || d == 0) return 0;
      frames_tab[n_frames] = '{x: x, y: y, w: w, h: h, dur: d};
      n_frames++;
      return 1;
   endfunction

   // step through frames while the timer covers the frame duration
   function automatic void advance_frames();
      clip_entry_type c;
      bit folded;
      int unsigned guard, idx, d, total;
      c = clips_tab[cur_clip];
      folded = 0;
      for (guard = 0; guard < 4 * MAX_FRAMES + 4; guard++) begin
         idx = c.first + pos;
         if (idx >= n_frames) return;
         d = frames_tab[idx].dur;
         if (d == 0 || timer < d) return;
         timer -= d;
         pos++;
         if (pos >= c.count) begin
            if (c.loop) begin
               pos = 0;
               if (!folded) begin
                  total = 0;
                  for (int k = 0; k < c.count && c.first + k < n_frames; k++)
                     total += frames_tab[c.first + k].dur;
                  if (total != 0) timer = timer % total;
                  folded = 1;
               end
            end else begin
               pos = c.count - 1;
               playing_q = 0;
               finished_q = 1;
               return;
            end
         end
      end
   endfunction

   function automatic rsp_beat_type predict_sequencer(req_beat_type r);
      rsp_beat_type o;
      int           sf, sx;
      int unsigned  add;
      o = '{default: '0};
      case (r.kind)
         REQ_CLEAR: begin
            n_frames = 0;
            n_clips = 0;
         end
         REQ_FRAME: begin
            o.assigned = n_frames;
            if (!push_frame(r.x, r.y, r.w, r.h, r.dur)) begin
               o.status = 1;
               o.assigned = 0;
            end
         end
         REQ_STRIP: begin
            o.assigned = n_frames;
            if (r.w == 0 || r.h == 0 || r.count == 0 || r.dur == 0) begin
               o.status = 1;
               o.assigned = 0;
            end else begin
               for (int i = 0; i < r.count; i++) begin
                  sx = int'(r.x) + int'(r.w) * i;
                  if (sx > 32767) sx = 32767;
                  if (!push_frame(sx[15:0], r.y, r.w, r.h, r.dur)) begin
                     o.status = 1;
                     break;
                  end
               end
            end
         end
         REQ_CLIP: begin
            if (n_clips >= MAX_CLIPS || r.count == 0 || r.first + r.count > n_frames)
               o.status = 1;
            else begin
               clips_tab[n_clips] = '{first: r.first, count: r.count, loop: r.loop};
               o.assigned = n_clips;
               n_clips++;
            end
         end
         REQ_PLAY: begin
            if (r.clip >= n_clips) o.status = 1;
            else if (r.restart || !selected || cur_clip != r.clip) begin
               cur_clip = r.clip;
               selected = 1;
               pos = 0;
               timer = 0;
               playing_q = 1;
               finished_q = 0;
               if (shown_index() < 0) o.status = 1;
               else o.rvalid = 1;
            end
         end
         REQ_STOP: playing_q = 0;
         REQ_TICK: begin
            if (playing_q) begin
               if (!clip_live()) o.status = 1;
               else begin
                  add = (r.dt * speed_q) >> 8;
                  timer = (timer + add > TIMER_MAX) ? TIMER_MAX : timer + add;
                  if (shown_index() < 0) o.status = 1;
                  else begin
                     advance_frames();
                     if (shown_index() < 0) o.status = 1;
                     else o.rvalid = 1;
                  end
               end
            end
         end
         default: begin
            cur_clip = 0;
            selected = 0;
            pos = 0;
            timer = 0;
            playing_q = 0;
            finished_q = 0;
            speed_q = SPEED_RESET;
         end
      endcase
      sf = shown_index();
      if (sf >= 0) begin
         o.frame = sf;
         o.rx = frames_tab[sf].x;
         o.ry = frames_tab[sf].y;
         o.rw = frames_tab[sf].w;
         o.rh = frames_tab[sf].h;
      end
      o.playing = playing_q;
      o.finished = finished_q;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // every third phase runs with no gaps or stalls; the others draw them at random
   bit no_gaps = 0;
   function automatic int gap_draw();
      if (no_gaps) return 0;
      return $urandom_range(0, 11);
   endfunction

   // ------------------------------------------------------------------
   // Driver: present beats at the falling edge, hold until accepted
   // ------------------------------------------------------------------
   int drv_gap = 0;
   bit req_taken = 0;
   initial begin
      req_bus.valid = 0;
      {req_bus.req_type, req_bus.rect_x, req_bus.rect_y, req_bus.rect_w,
       req_bus.rect_h, req_bus.duration, req_bus.start_frame, req_bus.frame_num,
       req_bus.loop_mode, req_bus.clip_sel, req_bus.restart, req_bus.dt} = '0;
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) req_taken = 1;
   end

   always @(negedge clock) begin
      req_beat_type r;
      bit           free;
      if (!reset) begin
         // once the beat has been taken, draw the gap before the next one
         free = !req_bus.valid || req_taken;
         if (req_taken) begin
            req_taken = 0;
            drv_gap = gap_draw();
         end
         if (free) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               r = pending_reqs.pop_front();
               expected_rsps.push_back(predict_sequencer(r));
               req_bus.req_type    <= r.kind;
               req_bus.rect_x      <= r.x;
               req_bus.rect_y      <= r.y;
               req_bus.rect_w      <= r.w;
               req_bus.rect_h      <= r.h;
               req_bus.duration    <= r.dur;
               req_bus.start_frame <= r.first;
               req_bus.frame_num   <= r.count;
               req_bus.loop_mode   <= r.loop;
               req_bus.clip_sel    <= r.clip;
               req_bus.restart     <= r.restart;
               req_bus.dt          <= r.dt;
               req_bus.valid       <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: random stalls on ready, compare at the rising edge
   // ------------------------------------------------------------------
   int snk_wait = 0;
   bit rsp_taken = 0;
   initial rsp_bus.ready = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 0;
            snk_wait = gap_draw();
         end
         if (snk_wait > 0) begin
            snk_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_beat_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_taken = 1;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result beat", 16'd0, 16'd0);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_bus.status !== e.status) report_mismatch("status", rsp_bus.status, e.status);
            if (rsp_bus.assigned_index !== e.assigned)
               report_mismatch("assigned_index", rsp_bus.assigned_index, e.assigned);
            if (rsp_bus.frame_shown !== e.frame)
               report_mismatch("frame_shown", rsp_bus.frame_shown, e.frame);
            if (rsp_bus.region_x !== e.rx) report_mismatch("region_x", rsp_bus.region_x, e.rx);
            if (rsp_bus.region_y !== e.ry) report_mismatch("region_y", rsp_bus.region_y, e.ry);
            if (rsp_bus.region_w !== e.rw) report_mismatch("region_w", rsp_bus.region_w, e.rw);
            if (rsp_bus.region_h !== e.rh) report_mismatch("region_h", rsp_bus.region_h, e.rh);
            if (rsp_bus.region_valid !== e.rvalid)
               report_mismatch("region_valid", rsp_bus.region_valid, e.rvalid);
            if (rsp_bus.playing !== e.playing) report_mismatch("playing", rsp_bus.playing, e.playing);
            if (rsp_bus.finished !== e.finished)
               report_mismatch("finished", rsp_bus.finished, e.finished);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic req_beat_type blank_req(req_code_type k);
      req_beat_type r;
      r.kind = k;
      r.x = $urandom; r.y = $urandom;
      r.w = $urandom; r.h = $urandom; r.dur = $urandom;
      r.first = $urandom; r.count = $urandom_range(0, 64);
      r.loop = $urandom; r.clip = $urandom; r.restart = $urandom; r.dt = $urandom;
      return r;
   endfunction

   function automatic req_beat_type frame_req(logic [15:0] w, logic [15:0] h,
                                              logic [15:0] d);
      req_beat_type r;
      r = blank_req(REQ_FRAME);
      r.w = w; r.h = h; r.dur = d;
      return r;
   endfunction

   function automatic req_beat_type clip_req(int f, int c, bit l);
      req_beat_type r;
      r = blank_req(REQ_CLIP);
      r.first = f; r.count = c; r.loop = l;
      return r;
   endfunction

   function automatic req_beat_type play_req(int c, bit rs);
      req_beat_type r;
      r = blank_req(REQ_PLAY);
      r.clip = c; r.restart = rs;
      return r;
   endfunction

   function automatic req_beat_type tick_req(logic [15:0] dt);
      req_beat_type r;
      r = blank_req(REQ_TICK);
      r.dt = dt;
      return r;
   endfunction

   // frame durations mostly short so ticks walk through several frames
   function automatic logic [15:0] pick_dur();
      case ($urandom_range(0, 5))
         0: return 16'hFFFF;
         1: return $urandom;
         default: return $urandom_range(1, 16'h2000);
      endcase
   endfunction

   function automatic logic [15:0] pick_dt();
      case ($urandom_range(0, 5))
         0: return 16'hFFFF;
         1: return 0;
         2: return $urandom;
         default: return $urandom_range(0, 16'h1800);
      endcase
   endfunction

   // wait until every result is in, then let the block settle
   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_bus.valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // write speed between phases only, while nothing is in flight
   task automatic write_speed(logic [11:0] v);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      speed_q = v;
   endtask

   // one animation session with random content, invalid requests included
   task automatic queue_session();
      req_beat_type r;
      int nf, nc;
      if ($urandom_range(0, 3) == 0) pending_reqs.push_back(blank_req(REQ_CLEAR));
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 1)) begin
            r = blank_req(REQ_STRIP);
            r.w = $urandom_range(0, 9) == 0 ? 16'hFFFF : $urandom_range(1, 64);
            r.h = $urandom_range(1, 65535);
            r.dur = pick_dur();
            r.count = $urandom_range(0, 9) == 0 ? $urandom_range(0, 64)
                                               : $urandom_range(1, 8);
         end else
            r = frame_req($urandom_range(1, 65535), $urandom_range(1, 65535), pick_dur());
         pending_reqs.push_back(r);
      end
      nf = $urandom_range(1, 12);
      repeat ($urandom_range(1, 3)) begin
         nc = $urandom_range(1, 6);
         pending_reqs.push_back(clip_req($urandom_range(0, nf), nc, $urandom));
      end
      pending_reqs.push_back(play_req($urandom_range(0, 15), $urandom));
      repeat ($urandom_range(2, 10)) begin
         case ($urandom_range(0, 15))
            0: pending_reqs.push_back(blank_req(REQ_STOP));
            1: pending_reqs.push_back(play_req($urandom_range(0, 15), $urandom));
            2: pending_reqs.push_back(blank_req(req_code_type'($urandom_range(0, 7))));
            default: pending_reqs.push_back(tick_req(pick_dt()));
         endcase
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      req_beat_type r;
      n_frames = 0; n_clips = 0; cur_clip = 0; selected = 0; pos = 0; timer = 0;
      playing_q = 0; finished_q = 0; speed_q = SPEED_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-table cases, rejects, extremes, once and loop
      pending_reqs.push_back(tick_req(16'hFFFF));
      pending_reqs.push_back(play_req(0, 0));
      pending_reqs.push_back(frame_req(0, 5, 5));
      pending_reqs.push_back(frame_req(5, 0, 5));
      pending_reqs.push_back(frame_req(5, 5, 0));
      r = frame_req(16'hFFFF, 16'hFFFF, 16'h1000);
      r.x = 16'sh8000; r.y = 16'sh7FFF;
      pending_reqs.push_back(r);
      r = blank_req(REQ_STRIP);
      r.x = 16'sh7FF0; r.y = 16'sh8000; r.w = 16'd100; r.h = 1; r.dur = 1; r.count = 3;
      pending_reqs.push_back(r);
      pending_reqs.push_back(clip_req(0, 0, 1));
      pending_reqs.push_back(clip_req(63, 64, 1));
      pending_reqs.push_back(clip_req(2, 3, 1));
      pending_reqs.push_back(clip_req(0, 2, 0));
      pending_reqs.push_back(play_req(15, 1));
      pending_reqs.push_back(play_req(1, 0));
      pending_reqs.push_back(tick_req(16'h1000));
      pending_reqs.push_back(tick_req(16'hFFFF));
      pending_reqs.push_back(play_req(1, 0));
      pending_reqs.push_back(play_req(0, 1));
      pending_reqs.push_back(tick_req(16'hFFFF));
      pending_reqs.push_back(blank_req(REQ_STOP));
      pending_reqs.push_back(tick_req(16'h0005));
      pending_reqs.push_back(blank_req(REQ_CLEAR));
      pending_reqs.push_back(play_req(0, 0));
      r = blank_req(REQ_STRIP);
      r.w = 1; r.h = 1; r.dur = 16'hFFFF; r.count = 64;
      pending_reqs.push_back(r);
      pending_reqs.push_back(frame_req(1, 1, 1));
      pending_reqs.push_back(blank_req(REQ_RESET));

      // speed phases: extremes first, then random; reset request restores it
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_speed(12'd0);
            1: write_speed(12'hFFF);
            2: write_speed(SPEED_RESET);
            default: write_speed($urandom);
         endcase
         no_gaps = (ph % 3 == 2);
         for (int n = 0; n < 230 / 6 && pending_reqs.size() < 220;) begin
            queue_session();
            n++;
         end
      end
      drain();
      stimulus_done = 1;
   end

   // ------------------------------------------------------------------
   // End of run
   // ------------------------------------------------------------------
   initial begin
      wait (stimulus_done);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // generous limit: every beat at its slowest with full stalls on both sides
   initial begin
      #(12 * 10000000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
hdl/sfs_pkg.sv
hdl/sfs_if.sv
hdl/sfs_frame_store.sv
hdl/sfs_clip_store.sv
hdl/sfs_mod_unit.sv
hdl/sprite_frame_sequencer.sv
bench/tb_sfs_pkg.sv
bench/tb_sprite_frame_sequencer.sv
